### sv/msis_pkg.sv
// shared types and constants for the max-sum increasing subsequence block
package msis_pkg;

	localparam int VAL_W       = 31;
	localparam int SUM_W       = 41;
	localparam int MAX_LEN_DEF = 1024;

	typedef logic [VAL_W-1:0] val_t;
	typedef logic [SUM_W-1:0] sum_t;

	localparam sum_t SUM_MAX = {SUM_W{1'b1}};

	// control from the sequencer to the predecessor picker
	typedef struct packed {
		logic clr;
		logic upd;
	} pick_ctrl_t;

endpackage

### sv/msis_if.sv
// valid/ready channel interfaces for the input and result words
interface msis_in_if import msis_pkg::*; ();
	logic valid;
	logic ready;
	val_t value;
	logic last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

interface msis_out_if import msis_pkg::*; ();
	logic valid;
	logic ready;
	sum_t max_sum;
	logic overflowed;

	modport source (output valid, output max_sum, output overflowed, input ready);
	modport sink (input valid, input max_sum, input overflowed, output ready);
endinterface

### sv/msis_pick.sv
// running best predecessor sum over the entries read back from the store
module msis_pick import msis_pkg::*; (
	input  logic       clk,
	input  pick_ctrl_t ctrl,
	input  val_t       val,
	input  val_t       ent_val,
	input  sum_t       ent_sum,
	output sum_t       pred
);

	sum_t pred_q;

	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			// start point: value 0, sum 0
			pred_q <= '0;
		end else if (ctrl.upd && (ent_val < val) && (ent_sum > pred_q)) begin
			pred_q <= ent_sum;
		end
	end

	assign pred = pred_q;

endmodule

### sv/max_sum_increasing_subsequence_top.sv
// max-sum strictly increasing subsequence over a stream of words, one stored entry per word
// an input word scans the entry store with one read per stored entry, waits for the last read,
// then takes a write-back and a finishing state; ready is low meanwhile
// a word that finds the store full is dropped and goes straight to the finishing state
// a result word is registered after the finishing state of the last word and held while the
// next word is taken; a last word waits in its finishing state while an older result is held
// arst_n clears the sequence count, running maximum and drop flag; the store needs no clearing
module max_sum_increasing_subsequence_top import msis_pkg::*; #(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	msis_in_if.sink           in_ch,
	msis_out_if.source        out_ch
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW = $clog2(MAX_LEN + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_LEN);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_WRITE, ST_DONE} state_t;

	typedef struct packed {
		val_t v;
		sum_t s;
	} entry_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;
	logic            rd_vld_s1;
	entry_t          rd_data_s1;
	val_t            val_q;
	logic            last_q;
	sum_t            best_q;
	logic            drop_q;
	logic            out_valid_q;
	sum_t            out_sum_q;
	logic            out_ovf_q;

	entry_t          mem [MAX_LEN];

	logic            in_fire;
	logic            rd_en;
	logic            wr_en;
	logic            out_load;
	sum_t            pred;
	logic [SUM_W:0]  sum_ext;
	sum_t            new_sum;
	pick_ctrl_t      pick_ctrl;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign rd_en    = (state_q == ST_SCAN) && (idx_q != count_q);
	assign wr_en    = (state_q == ST_WRITE);
	assign out_load = (state_q == ST_DONE) && last_q && (!out_valid_q || out_ch.ready);

	// saturate the new entry sum at the top of its range
	assign sum_ext = {1'b0, pred} + (SUM_W+1)'(val_q);
	assign new_sum = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];

	assign pick_ctrl.clr = in_fire;
	assign pick_ctrl.upd = rd_vld_s1;

	msis_pick u_pick (
		.clk     (clk),
		.ctrl    (pick_ctrl),
		.val     (val_q),
		.ent_val (rd_data_s1.v),
		.ent_sum (rd_data_s1.s),
		.pred    (pred)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[AW-1:0]] <= '{v: val_q, s: new_sum};
		end
		if (rd_en) begin
			rd_data_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			val_q       <= '0;
			last_q      <= 1'b0;
			best_q      <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_sum_q   <= '0;
			out_ovf_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.valid && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						val_q  <= in_ch.value;
						last_q <= in_ch.last;
						idx_q  <= '0;
						if (count_q == FULL) begin
							// store full: word is dropped but still ends the sequence if last
							drop_q  <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						idx_q <= idx_q + CW'(1);
					end else if (!rd_vld_s1) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					count_q <= count_q + CW'(1);
					if (new_sum > best_q) begin
						best_q <= new_sum;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_load) begin
						out_sum_q   <= best_q;
						out_ovf_q   <= drop_q;
						count_q     <= '0;
						best_q      <= '0;
						drop_q      <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ch.ready       = (state_q == ST_IDLE);
	assign out_ch.valid      = out_valid_q;
	assign out_ch.max_sum    = out_sum_q;
	assign out_ch.overflowed = out_ovf_q;

endmodule
